@@ rtl/pcdf_pkg.sv @@
package pcdf_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int DUTY_W  = 7;
    localparam int FREQ_W  = 22;

    localparam int DUTY_QBITS = 7;
    localparam int FREQ_QBITS = 19;
    localparam int FREQ_SHIFT = 3;
    localparam int CNT_W      = 5;

    localparam logic [6:0]            DUTY_SCALE   = 7'd100;
    localparam logic [FREQ_QBITS-1:0] FREQ_NUM_LOW = 19'd475712;

    typedef enum logic [1:0] {
        EDGE_RISE  = 2'd0,
        EDGE_FALL  = 2'd1,
        EDGE_CLOSE = 2'd2,
        EDGE_SKIP  = 2'd3
    } edge_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DUTY,
        ST_FREQ,
        ST_DONE
    } calc_state_t;

endpackage

@@ rtl/pcdf_front.sv @@
module pcdf_front
    import pcdf_pkg::*;
#(
    parameter int STAMP_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic [1:0]             in_edge,
    input  logic [15:0]            in_stamp,
    output logic                   push,
    output logic [STAMP_WIDTH:0]   high_span,
    output logic [STAMP_WIDTH:0]   low_span
);

    logic [STAMP_WIDTH-1:0] rise_reg, rise_next;
    logic [STAMP_WIDTH-1:0] fall_reg, fall_next;
    logic [STAMP_WIDTH-1:0] stamp;
    logic [STAMP_WIDTH-1:0] high_diff;
    logic [STAMP_WIDTH-1:0] low_diff;
    edge_t                  edge_code;

    assign stamp     = STAMP_WIDTH'(in_stamp);
    assign edge_code = edge_t'(in_edge);
    assign high_diff = fall_reg - rise_reg;
    assign low_diff  = stamp - fall_reg;

    // zero difference means a full timer wrap
    assign high_span = {high_diff == '0, high_diff};
    assign low_span  = {low_diff == '0, low_diff};

    always_comb begin
        rise_next = rise_reg;
        fall_next = fall_reg;
        push      = 1'b0;
        if (in_fire) begin
            unique case (edge_code)
                EDGE_RISE: begin
                    rise_next = stamp;
                end
                EDGE_FALL: begin
                    fall_next = stamp;
                end
                EDGE_CLOSE: begin
                    push      = 1'b1;
                    rise_next = '0;
                    fall_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= '0;
            fall_reg <= '0;
        end else begin
            rise_reg <= rise_next;
            fall_reg <= fall_next;
        end
    end

endmodule

@@ rtl/pcdf_queue.sv @@
module pcdf_queue
    import pcdf_pkg::*;
#(
    parameter int WIDTH = 34
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/pcdf_calc.sv @@
module pcdf_calc
    import pcdf_pkg::*;
#(
    parameter int STAMP_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [STAMP_WIDTH:0]   in_high,
    input  logic [STAMP_WIDTH:0]   in_low,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int SPW   = STAMP_WIDTH + 1;
    localparam int PERW  = STAMP_WIDTH + 2;
    localparam int TRW   = STAMP_WIDTH + 3;
    localparam int PRODW = STAMP_WIDTH + 8;

    calc_state_t            state_reg, state_next;
    logic [SPW-1:0]         high_reg, high_next;
    logic [PERW-1:0]        period_reg, period_next;
    logic [PERW-1:0]        rem_reg, rem_next;
    logic [FREQ_QBITS-1:0]  num_reg, num_next;
    logic [FREQ_QBITS-1:0]  quo_reg, quo_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic [PRODW-1:0]       prod;
    logic [TRW-1:0]         trial;
    logic                   ge;
    logic [PERW-1:0]        rem_step;
    logic [FREQ_QBITS-1:0]  quo_step;

    assign prod     = {7'd0, high_reg} * PRODW'(DUTY_SCALE);
    assign trial    = {rem_reg, num_reg[FREQ_QBITS-1]};
    assign ge       = trial >= {1'b0, period_reg};
    assign rem_step = ge ? PERW'(trial - {1'b0, period_reg}) : PERW'(trial);
    assign quo_step = {quo_reg[FREQ_QBITS-2:0], ge};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        high_next      = high_reg;
        period_next    = period_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        duty_next      = duty_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    pop         = 1'b1;
                    high_next   = in_high;
                    period_next = PERW'(in_high) + PERW'(in_low);
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                // quotient below 128, so the top bits start as remainder
                rem_next   = PERW'(prod[PRODW-1:DUTY_QBITS]);
                num_next   = {prod[DUTY_QBITS-1:0], (FREQ_QBITS-DUTY_QBITS)'(0)};
                quo_next   = '0;
                cnt_next   = CNT_W'(DUTY_QBITS);
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                rem_next = rem_step;
                num_next = {num_reg[FREQ_QBITS-2:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    duty_next  = quo_step[DUTY_W-1:0];
                    // 1000000 = 1 * 2^19 + low bits
                    rem_next   = PERW'(1);
                    num_next   = FREQ_NUM_LOW;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(FREQ_QBITS);
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ: begin
                rem_next = rem_step;
                num_next = {num_reg[FREQ_QBITS-2:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_TDATA_W'({quo_reg[FREQ_QBITS-1:0],
                                                FREQ_SHIFT'(0), duty_reg});
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_reg     <= high_next;
        period_reg   <= period_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        duty_reg     <= duty_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/pwm_capture_duty_frequency.sv @@
// a closing-edge transfer reaches m_tvalid through the queue, the load, the
// multiply, the duty divide, the frequency divide and the output register
// throughput: one input transfer per cycle while the two-entry queue has room;
// closing edges are worked one at a time by the shared serial divider
// reset: synchronous active-low aresetn clears both stored stamps, the queue
// and the output valid flag
module pwm_capture_duty_frequency
    import pcdf_pkg::*;
#(
    parameter int STAMP_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // edge_index[1:0], capture_stamp[17:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // duty_percent[6:0], frequency_value[28:7]
);

    logic                  push;
    logic                  full;
    logic                  pop;
    logic                  q_valid;
    logic [STAMP_WIDTH:0]  high_span;
    logic [STAMP_WIDTH:0]  low_span;
    logic [2*STAMP_WIDTH+1:0] q_data;

    assign s_tready = !full;

    pcdf_front #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid && s_tready),
        .in_edge   (s_tdata[1:0]),
        .in_stamp  (s_tdata[17:2]),
        .push      (push),
        .high_span (high_span),
        .low_span  (low_span)
    );

    pcdf_queue #(
        .WIDTH (2*STAMP_WIDTH+2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({low_span, high_span}),
        .full      (full),
        .pop       (pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    pcdf_calc #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_high  (q_data[STAMP_WIDTH:0]),
        .in_low   (q_data[2*STAMP_WIDTH+1:STAMP_WIDTH+1]),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/pcdf_check.sv @@
module pcdf_check
    import pcdf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] <= 7'd100)
        else $error("duty above 100");

    a_freq_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:7] == 3'd0 && m_tdata[28:7] <= 22'd4000000
                     && m_tdata[31:29] == 3'd0)
        else $error("frequency field malformed");

endmodule

bind pwm_capture_duty_frequency pcdf_check u_check (.*);

@@ tb/pwm_capture_duty_frequency_tb.sv @@
module pwm_capture_duty_frequency_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcdf_pkg::*;

    localparam int unsigned PERCENT_SCALE  = 100;
    localparam int unsigned FREQ_NUMERATOR = 1000000;
    localparam int unsigned TICK_SCALE     = 8;
    localparam int unsigned FULL_WRAP      = 32'h10000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PHASE_ITEMS    = 360;
    localparam int          HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [FREQ_W-1:0] freq;
    } pwm_result_t;

    class pwm_scoreboard;
        logic [15:0]  rise_stamp;
        logic [15:0]  fall_stamp;
        pwm_result_t  expected_q[$];
        int           errors;
        int           result_idx;

        function new();
            rise_stamp = '0;
            fall_stamp = '0;
            errors     = 0;
            result_idx = 0;
        endfunction

        // wrapped difference, zero counts as a full timer wrap
        function int unsigned wrap_span(logic [15:0] from_s, logic [15:0] to_s);
            logic [15:0] d;
            d = to_s - from_s;
            return (d == 16'd0) ? FULL_WRAP : {16'd0, d};
        endfunction

        function void note_capture(edge_t kind, logic [15:0] stamp);
            int unsigned high_t;
            int unsigned low_t;
            int unsigned period;
            pwm_result_t r;
            case (kind)
                EDGE_RISE: begin
                    rise_stamp = stamp;
                end
                EDGE_FALL: begin
                    fall_stamp = stamp;
                end
                EDGE_CLOSE: begin
                    high_t = wrap_span(rise_stamp, fall_stamp);
                    low_t  = wrap_span(fall_stamp, stamp);
                    period = high_t + low_t;
                    r.duty = DUTY_W'((high_t * PERCENT_SCALE) / period);
                    r.freq = FREQ_W'((FREQ_NUMERATOR / period) * TICK_SCALE);
                    expected_q.push_back(r);
                    rise_stamp = '0;
                    fall_stamp = '0;
                end
                default: begin
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [DUTY_W-1:0] duty, logic [FREQ_W-1:0] freq);
            pwm_result_t exp_r;
            result_idx++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d unexpected: duty %0d freq %0d",
                                 result_idx, duty, freq));
                return;
            end
            exp_r = expected_q.pop_front();
            if (duty !== exp_r.duty)
                report($sformatf("result %0d duty %0d, want %0d",
                                 result_idx, duty, exp_r.duty));
            if (freq !== exp_r.freq)
                report($sformatf("result %0d freq %0d, want %0d",
                                 result_idx, freq, exp_r.freq));
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // edge_index[1:0], capture_stamp[17:2]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // duty_percent[6:0], frequency_value[28:7]

    pwm_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int stall_cycles   = 0;
    int stim_count     = 0;

    pwm_capture_duty_frequency dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sample both channels mid-cycle, transfer completes at the next rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_capture(edge_t'(s_tdata[1:0]), s_tdata[17:2]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[6:0], m_tdata[28:7]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_capture(input edge_t kind, input logic [15:0] stamp);
        bit ready_seen;
        ready_seen = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, stamp, kind};
        while (!ready_seen) begin
            @(negedge aclk);
            ready_seen = s_tready;
        end
        @(posedge aclk);
        if (kind != EDGE_SKIP)
            stim_count++;
    endtask

    function automatic logic [15:0] pick_span();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(1, 8));
            1:       return 16'($urandom_range(0, 300));
            2:       return 16'($urandom);
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_frame();
        logic [15:0] rise_t;
        logic [15:0] fall_t;
        logic [15:0] close_t;
        int unsigned pick;
        rise_t  = 16'($urandom);
        fall_t  = rise_t + pick_span();
        close_t = fall_t + pick_span();
        pick    = $urandom_range(99);
        if (pick < 8)
            send_capture(EDGE_SKIP, 16'($urandom));
        if (pick >= 8 && pick < 20) begin
            // broken sequence: a lone rising, falling or closing edge
            send_capture(edge_t'($urandom_range(2)), 16'($urandom));
        end else begin
            send_capture(EDGE_RISE, rise_t);
            if ($urandom_range(9) == 0)
                send_capture(EDGE_SKIP, 16'($urandom));
            send_capture(EDGE_FALL, fall_t);
            send_capture(EDGE_CLOSE, close_t);
        end
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = stim_count;
        while (stim_count - start < n_items)
            send_frame();
    endtask

    task automatic run_directed();
        send_capture(EDGE_SKIP,  16'hFFFF);
        // closing edge straight after reset, both spans a full wrap
        send_capture(EDGE_CLOSE, 16'h0000);
        send_capture(EDGE_SKIP,  16'h0000);
        // shortest period
        send_capture(EDGE_RISE,  16'h0000);
        send_capture(EDGE_FALL,  16'h0001);
        send_capture(EDGE_CLOSE, 16'h0002);
        // equal stamps everywhere
        send_capture(EDGE_RISE,  16'hFFFF);
        send_capture(EDGE_FALL,  16'hFFFF);
        send_capture(EDGE_CLOSE, 16'hFFFF);
        // long high, short low
        send_capture(EDGE_RISE,  16'h0000);
        send_capture(EDGE_FALL,  16'hFFFF);
        send_capture(EDGE_CLOSE, 16'h0000);
        // short high, full-wrap low
        send_capture(EDGE_RISE,  16'h0000);
        send_capture(EDGE_FALL,  16'h0001);
        send_capture(EDGE_CLOSE, 16'h0001);
        // timer wraps inside the frame, ignored edge in between
        send_capture(EDGE_RISE,  16'hFFF0);
        send_capture(EDGE_FALL,  16'h0010);
        send_capture(EDGE_SKIP,  16'h1234);
        send_capture(EDGE_CLOSE, 16'h0100);
        // missing earlier edges
        send_capture(EDGE_CLOSE, 16'h5555);
        send_capture(EDGE_FALL,  16'hAAAA);
        send_capture(EDGE_CLOSE, 16'hAAAB);
        send_capture(EDGE_RISE,  16'h8000);
        send_capture(EDGE_CLOSE, 16'h8001);
        // repeated rising edge, the later one counts
        send_capture(EDGE_RISE,  16'h0001);
        send_capture(EDGE_RISE,  16'h0003);
        send_capture(EDGE_FALL,  16'h0004);
        send_capture(EDGE_CLOSE, 16'h0005);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        send_idle_pct = 67; recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;  recv_stall_pct = 67;
        run_random(PHASE_ITEMS);
        send_idle_pct = 25; recv_stall_pct = 25;
        run_random(PHASE_ITEMS);

        // receiver holds off while the sender keeps offering
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_request  = HOLD_CYCLES;
        run_random(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
